[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the steer decider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TBSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TBSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TBSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define TBSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/tbsd_pkg.sv]
// Package with the types, widths and codes of the steer decider.
package tbsd_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAME_BITS = 12;
    localparam int MARGIN_BITS = 8;
    localparam int TIMEOUT_BITS = 16;
    localparam int STAMP_BITS = 32;
    localparam int AREA_W = 2 * COORD_BITS;
    localparam int AREA_CMP_W = AREA_W + 3;
    localparam int CTR_W = COORD_BITS + 1;
    localparam int BAND_W = ((CTR_W + 4) > (FRAME_BITS + 3)) ? (CTR_W + 4) : (FRAME_BITS + 3);
    localparam int MOVE_W = ((COORD_BITS + 2) > (MARGIN_BITS + 1)) ? (COORD_BITS + 2)
                                                                    : (MARGIN_BITS + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEER_W = 4;
    localparam int ACCEL_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MARGIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MARGIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd4;

    localparam logic [STEER_W-1:0] STEER_LEFT     = 4'd4;
    localparam logic [STEER_W-1:0] STEER_STRAIGHT = 4'd6;
    localparam logic [STEER_W-1:0] STEER_RIGHT    = 4'd8;
    localparam logic [ACCEL_W-1:0] ACCEL_SLOW     = 2'd1;
    localparam logic [ACCEL_W-1:0] ACCEL_NORMAL   = 2'd3;

    localparam logic MODE_BOX  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [1:0] COUNT_FULL = 2'd2;

    typedef struct packed {
        logic                  mode;
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [COORD_BITS-1:0] box_w;
        logic [COORD_BITS-1:0] box_h;
        logic [STAMP_BITS-1:0] stamp_ms;
    } t_item;

    typedef struct packed {
        logic [FRAME_BITS-1:0]   frame_width;
        logic [FRAME_BITS-1:0]   frame_height;
        logic [MARGIN_BITS-1:0]  x_margin;
        logic [MARGIN_BITS-1:0]  y_margin;
        logic [TIMEOUT_BITS-1:0] stale_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic clear;
    } t_hist_ctl;

    typedef struct packed {
        logic [1:0]            count;
        logic [COORD_BITS-1:0] newest_x;
        logic [COORD_BITS-1:0] newest_y;
        logic [CTR_W-1:0]      newest_cx;
        logic [CTR_W-1:0]      newest_cy;
        logic [COORD_BITS-1:0] older_x;
        logic [COORD_BITS-1:0] older_y;
    } t_hist;

    typedef struct packed {
        logic [STEER_W-1:0] steer;
        logic [ACCEL_W-1:0] accel;
        logic               change;
    } t_decision;

endpackage

[rtl/tbsd_in_if.sv]
// Input channel of the steer decider: box reports and decision ticks.
interface tbsd_in_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [tbsd_pkg::COORD_BITS-1:0] box_x;
    logic [tbsd_pkg::COORD_BITS-1:0] box_y;
    logic [tbsd_pkg::COORD_BITS-1:0] box_w;
    logic [tbsd_pkg::COORD_BITS-1:0] box_h;
    logic [tbsd_pkg::STAMP_BITS-1:0] stamp_ms;

    modport source (output valid, mode, box_x, box_y, box_w, box_h, stamp_ms, input ready);
    modport sink (input valid, mode, box_x, box_y, box_w, box_h, stamp_ms, output ready);
endinterface

[rtl/tbsd_out_if.sv]
// Output channel of the steer decider: changed steering and acceleration codes.
interface tbsd_out_if;
    logic                         valid;
    logic                         ready;
    logic [tbsd_pkg::STEER_W-1:0] steer_cmd;
    logic [tbsd_pkg::ACCEL_W-1:0] accel_cmd;

    modport source (output valid, steer_cmd, accel_cmd, input ready);
    modport sink (input valid, steer_cmd, accel_cmd, output ready);
endinterface

[rtl/tbsd_history.sv]
// Box history: continuity checks on box reports and the last two boxes.
module tbsd_history (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tbsd_pkg::t_hist_ctl             i_ctl,
    input  tbsd_pkg::t_item                 i_item,
    input  logic [tbsd_pkg::TIMEOUT_BITS-1:0] i_timeout,
    output tbsd_pkg::t_hist                 o_hist
);

    logic [1:0]                            r_count;
    logic [tbsd_pkg::COORD_BITS-1:0]       r_newest_x;
    logic [tbsd_pkg::COORD_BITS-1:0]       r_newest_y;
    logic [tbsd_pkg::CTR_W-1:0]            r_newest_cx;
    logic [tbsd_pkg::CTR_W-1:0]            r_newest_cy;
    logic [tbsd_pkg::COORD_BITS-1:0]       r_older_x;
    logic [tbsd_pkg::COORD_BITS-1:0]       r_older_y;
    logic [tbsd_pkg::AREA_W-1:0]           r_area;
    logic [tbsd_pkg::STAMP_BITS-1:0]       r_stamp;

    logic [1:0]                            n_count;
    logic [tbsd_pkg::STAMP_BITS-1:0]       gap;
    logic [tbsd_pkg::AREA_W-1:0]           new_area;
    logic [tbsd_pkg::AREA_CMP_W-1:0]       old_x4, old_x5, new_x4, new_x5;
    logic                                  stale;
    logic                                  area_jump;
    logic                                  discard;

    // The stamp difference wraps; a negative gap never counts as stale.
    assign gap = i_item.stamp_ms - r_stamp;
    assign stale = $signed(gap) > $signed({{(tbsd_pkg::STAMP_BITS -
                   tbsd_pkg::TIMEOUT_BITS){1'b0}}, i_timeout});

    assign new_area = tbsd_pkg::AREA_W'(i_item.box_w) * tbsd_pkg::AREA_W'(i_item.box_h);
    assign old_x4 = {1'b0, r_area, 2'b00};
    assign old_x5 = {1'b0, r_area, 2'b00} + tbsd_pkg::AREA_CMP_W'(r_area);
    assign new_x4 = {1'b0, new_area, 2'b00};
    assign new_x5 = {1'b0, new_area, 2'b00} + tbsd_pkg::AREA_CMP_W'(new_area);
    assign area_jump = (old_x5 < new_x4) || (old_x4 > new_x5);

    assign discard = (r_count != 2'd0) && (stale || area_jump);

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = 2'd0;
        end else if (i_ctl.take) begin
            if (discard) begin
                n_count = 2'd1;
            end else if (r_count != tbsd_pkg::COUNT_FULL) begin
                n_count = r_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_older_x   <= r_newest_x;
            r_older_y   <= r_newest_y;
            r_newest_x  <= i_item.box_x;
            r_newest_y  <= i_item.box_y;
            r_newest_cx <= tbsd_pkg::CTR_W'(i_item.box_x) +
                           tbsd_pkg::CTR_W'(i_item.box_w[tbsd_pkg::COORD_BITS-1:1]);
            r_newest_cy <= tbsd_pkg::CTR_W'(i_item.box_y) +
                           tbsd_pkg::CTR_W'(i_item.box_h[tbsd_pkg::COORD_BITS-1:1]);
            r_area      <= new_area;
            r_stamp     <= i_item.stamp_ms;
        end
    end

    assign o_hist.count     = r_count;
    assign o_hist.newest_x  = r_newest_x;
    assign o_hist.newest_y  = r_newest_y;
    assign o_hist.newest_cx = r_newest_cx;
    assign o_hist.newest_cy = r_newest_cy;
    assign o_hist.older_x   = r_older_x;
    assign o_hist.older_y   = r_older_y;

endmodule

[rtl/tbsd_decide.sv]
// Decision logic: edge bands and motion margins to steering and acceleration codes.
module tbsd_decide (
    input  tbsd_pkg::t_hist                 i_hist,
    input  tbsd_pkg::t_cfg                  i_cfg,
    input  logic [tbsd_pkg::STEER_W-1:0]    i_steer_now,
    input  logic [tbsd_pkg::ACCEL_W-1:0]    i_accel_now,
    output tbsd_pkg::t_decision             o_dec
);

    logic [tbsd_pkg::BAND_W-1:0]        cy10, cx5, h3, h7, w1, w4;
    logic signed [tbsd_pkg::MOVE_W-1:0] dx, dy, xm, ym;
    logic [tbsd_pkg::STEER_W-1:0]       steer;
    logic [tbsd_pkg::ACCEL_W-1:0]       accel;

    assign cy10 = tbsd_pkg::BAND_W'(i_hist.newest_cy) * tbsd_pkg::BAND_W'(10);
    assign cx5  = tbsd_pkg::BAND_W'(i_hist.newest_cx) * tbsd_pkg::BAND_W'(5);
    assign h3   = tbsd_pkg::BAND_W'(i_cfg.frame_height) * tbsd_pkg::BAND_W'(3);
    assign h7   = tbsd_pkg::BAND_W'(i_cfg.frame_height) * tbsd_pkg::BAND_W'(7);
    assign w1   = tbsd_pkg::BAND_W'(i_cfg.frame_width);
    assign w4   = tbsd_pkg::BAND_W'({i_cfg.frame_width, 2'b00});

    assign dx = $signed(tbsd_pkg::MOVE_W'(i_hist.newest_x)) -
                $signed(tbsd_pkg::MOVE_W'(i_hist.older_x));
    assign dy = $signed(tbsd_pkg::MOVE_W'(i_hist.newest_y)) -
                $signed(tbsd_pkg::MOVE_W'(i_hist.older_y));
    assign xm = $signed(tbsd_pkg::MOVE_W'(i_cfg.x_margin));
    assign ym = $signed(tbsd_pkg::MOVE_W'(i_cfg.y_margin));

    // Inside an edge band the held code stays unless the box moves far enough outward.
    always_comb begin
        accel = i_accel_now;
        priority if (cy10 < h3) begin
            if (-dy > ym) accel = tbsd_pkg::ACCEL_SLOW;
        end else if (cy10 > h7) begin
            if (dy > ym) accel = tbsd_pkg::ACCEL_SLOW;
        end else begin
            accel = tbsd_pkg::ACCEL_NORMAL;
        end
    end

    always_comb begin
        steer = i_steer_now;
        priority if (cx5 < w1) begin
            if (-dx > xm) steer = tbsd_pkg::STEER_LEFT;
        end else if (cx5 > w4) begin
            if (dx > xm) steer = tbsd_pkg::STEER_RIGHT;
        end else begin
            steer = tbsd_pkg::STEER_STRAIGHT;
        end
    end

    assign o_dec.steer  = steer;
    assign o_dec.accel  = accel;
    assign o_dec.change = (steer != i_steer_now) || (accel != i_accel_now);

endmodule

[rtl/track_box_steer_decider.sv]
// Top level of the steer decider: input register, configuration and result register.
//
// Box reports (mode 0) and decision ticks (mode 1) arrive as beats on i_in.
// A report extends the two-box history, or restarts it when it comes too late
// after the newest box or its area differs too much. A tick with two boxes
// picks steering and acceleration codes from the newest box position and the
// motion, clears the history, and sends a beat on o_out only if a code changed.
// An accepted beat is held in the input register, then a result passes through
// the decision logic into the result register.
// The decider takes one beat per cycle while i_in.ready is high; the input
// register and the result register sit between the two channels, so a waiting
// result does not hold up reports or ticks that give no result.
// When o_out stalls with a result pending, only a tick that would change the
// codes waits in the input register; i_in.ready drops until the result leaves.
// Synchronous reset empties both registers and the history, sets steering to
// straight and acceleration to slow, and loads the default configuration.
// Configuration writes on i_cfg_we are taken at once; indexes past the list
// are ignored. Write only while no beat is in flight.
`include "assert_macros.svh"
module track_box_steer_decider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tbsd_in_if.sink                           i_in,
    tbsd_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [tbsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tbsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tbsd_pkg::t_cfg                 r_cfg;
    logic                           r_in_valid;
    tbsd_pkg::t_item                r_in;
    logic                           r_out_valid;
    logic [tbsd_pkg::STEER_W-1:0]   r_out_steer;
    logic [tbsd_pkg::ACCEL_W-1:0]   r_out_accel;
    logic [tbsd_pkg::STEER_W-1:0]   r_steer_now;
    logic [tbsd_pkg::ACCEL_W-1:0]   r_accel_now;

    tbsd_pkg::t_hist                w_hist;
    tbsd_pkg::t_hist_ctl            w_ctl;
    tbsd_pkg::t_decision            w_dec;
    logic                           tick_full;
    logic                           emit;
    logic                           out_free;
    logic                           advance;
    logic                           in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width      <= 12'd640;
            r_cfg.frame_height     <= 12'd480;
            r_cfg.x_margin         <= 8'd6;
            r_cfg.y_margin         <= 8'd3;
            r_cfg.stale_timeout_ms <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tbsd_pkg::CFG_FRAME_WIDTH: begin
                    r_cfg.frame_width <= i_cfg_data[tbsd_pkg::FRAME_BITS-1:0];
                end
                tbsd_pkg::CFG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data[tbsd_pkg::FRAME_BITS-1:0];
                end
                tbsd_pkg::CFG_X_MARGIN: begin
                    r_cfg.x_margin <= i_cfg_data[tbsd_pkg::MARGIN_BITS-1:0];
                end
                tbsd_pkg::CFG_Y_MARGIN: begin
                    r_cfg.y_margin <= i_cfg_data[tbsd_pkg::MARGIN_BITS-1:0];
                end
                tbsd_pkg::CFG_TIMEOUT: begin
                    r_cfg.stale_timeout_ms <= i_cfg_data[tbsd_pkg::TIMEOUT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The held beat moves on unless it produces a result that has nowhere to go.
    assign tick_full = r_in_valid && (r_in.mode == tbsd_pkg::MODE_TICK) &&
                       (w_hist.count == tbsd_pkg::COUNT_FULL);
    assign emit      = tick_full && w_dec.change;
    assign out_free  = !r_out_valid || o_out.ready;
    assign advance   = r_in_valid && (!emit || out_free);
    assign in_ready  = !r_in_valid || advance;

    assign w_ctl.take  = advance && (r_in.mode == tbsd_pkg::MODE_BOX);
    assign w_ctl.clear = advance && tick_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in.mode     <= i_in.mode;
            r_in.box_x    <= i_in.box_x;
            r_in.box_y    <= i_in.box_y;
            r_in.box_w    <= i_in.box_w;
            r_in.box_h    <= i_in.box_h;
            r_in.stamp_ms <= i_in.stamp_ms;
        end
    end

    tbsd_history u_history (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_item    (r_in),
        .i_timeout (r_cfg.stale_timeout_ms),
        .o_hist    (w_hist)
    );

    tbsd_decide u_decide (
        .i_hist      (w_hist),
        .i_cfg       (r_cfg),
        .i_steer_now (r_steer_now),
        .i_accel_now (r_accel_now),
        .o_dec       (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_steer_now <= tbsd_pkg::STEER_STRAIGHT;
            r_accel_now <= tbsd_pkg::ACCEL_SLOW;
        end else begin
            if (advance && emit) begin
                r_out_valid <= 1'b1;
                r_steer_now <= w_dec.steer;
                r_accel_now <= w_dec.accel;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_steer <= w_dec.steer;
            r_out_accel <= w_dec.accel;
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.steer_cmd = r_out_steer;
    assign o_out.accel_cmd = r_out_accel;

    `TBSD_ASSERT(a_count_range, i_clk, i_rst_n, w_hist.count != 2'd3, "box count out of range")
    `TBSD_ASSERT(a_out_from_tick, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_in_valid && r_in.mode == tbsd_pkg::MODE_TICK), "result without a tick")
    `TBSD_ASSERT(a_out_matches_held, i_clk, i_rst_n, r_out_valid |-> (r_out_steer == r_steer_now && r_out_accel == r_accel_now), "pending result differs from held codes")
    `TBSD_ASSERT_NEXT(a_tick_clears, i_clk, i_rst_n, w_ctl.clear, w_hist.count == 2'd0, "tick did not clear history")

endmodule

[dv/tb_track_box_steer_decider.sv]
// Self-checking testbench for the track box steer decider: directed cases, random traffic, stalls.
module tb_track_box_steer_decider;
    timeunit 1ns;
    timeprecision 1ps;

    import tbsd_pkg::*;

    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [STEER_W-1:0] steer;
        logic [ACCEL_W-1:0] accel;
    } t_cmd;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tbsd_in_if  in_ch ();
    tbsd_out_if out_ch ();

    track_box_steer_decider DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow of the decider: configuration, box history and held codes.
    t_cfg                  cfg_shadow;
    int unsigned           hist_count;
    logic [COORD_BITS-1:0] new_x, new_y, new_w, new_h;
    logic [COORD_BITS-1:0] old_x, old_y;
    logic [STAMP_BITS-1:0] new_stamp;
    t_cmd                  held_cmd;

    t_cmd                  pending_cmds[$];
    int                    error_count  = 0;
    int                    items_sent   = 0;
    int                    src_idle_pct = 0;
    int                    snk_idle_pct = 0;
    int                    hold_req     = 0;
    logic [STAMP_BITS-1:0] now_ms;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("%0t: mismatch on %s: got %0d, wanted %0d", $realtime, what, got, wanted);
        error_count++;
    endtask

    // Applies one accepted beat to the shadow and returns the command it causes, if any.
    function automatic void track_item(input t_item it, output bit changed, output t_cmd cmd);
        logic signed [STAMP_BITS-1:0] gap;
        longint old_area, new_area, cx, cy, dx, dy;
        t_cmd next_cmd;
        changed = 1'b0;
        cmd = held_cmd;
        if (it.mode == MODE_BOX) begin
            if (hist_count > 0) begin
                gap = it.stamp_ms - new_stamp;
                old_area = longint'(new_w) * longint'(new_h);
                new_area = longint'(it.box_w) * longint'(it.box_h);
                if (longint'(gap) > longint'(cfg_shadow.stale_timeout_ms))
                    hist_count = 0;
                else if (5 * old_area < 4 * new_area || 4 * old_area > 5 * new_area)
                    hist_count = 0;
            end
            old_x = new_x;
            old_y = new_y;
            new_x = it.box_x;
            new_y = it.box_y;
            new_w = it.box_w;
            new_h = it.box_h;
            new_stamp = it.stamp_ms;
            if (hist_count < 2)
                hist_count++;
        end else if (hist_count == 2) begin
            cx = longint'(new_x) + longint'(new_w / 2);
            cy = longint'(new_y) + longint'(new_h / 2);
            dx = longint'(new_x) - longint'(old_x);
            dy = longint'(new_y) - longint'(old_y);
            next_cmd = held_cmd;
            if (10 * cy < 3 * longint'(cfg_shadow.frame_height)) begin
                if (-dy > longint'(cfg_shadow.y_margin))
                    next_cmd.accel = ACCEL_SLOW;
            end else if (10 * cy > 7 * longint'(cfg_shadow.frame_height)) begin
                if (dy > longint'(cfg_shadow.y_margin))
                    next_cmd.accel = ACCEL_SLOW;
            end else begin
                next_cmd.accel = ACCEL_NORMAL;
            end
            if (5 * cx < longint'(cfg_shadow.frame_width)) begin
                if (-dx > longint'(cfg_shadow.x_margin))
                    next_cmd.steer = STEER_LEFT;
            end else if (5 * cx > 4 * longint'(cfg_shadow.frame_width)) begin
                if (dx > longint'(cfg_shadow.x_margin))
                    next_cmd.steer = STEER_RIGHT;
            end else begin
                next_cmd.steer = STEER_STRAIGHT;
            end
            hist_count = 0;
            if (next_cmd != held_cmd) begin
                held_cmd = next_cmd;
                changed = 1'b1;
                cmd = next_cmd;
            end
        end
    endfunction

    // Input beats feed the shadow; output beats are checked against the oldest command.
    always @(posedge i_clk) begin
        t_item seen;
        bit    changed;
        t_cmd  cmd;
        t_cmd  want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                seen = '{mode: in_ch.mode, box_x: in_ch.box_x, box_y: in_ch.box_y,
                         box_w: in_ch.box_w, box_h: in_ch.box_h, stamp_ms: in_ch.stamp_ms};
                track_item(seen, changed, cmd);
                if (changed)
                    pending_cmds.insert(pending_cmds.size(), cmd);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_cmds.size() == 0) begin
                    report_mismatch("unrequested command", {out_ch.steer_cmd, out_ch.accel_cmd}, -1);
                end else begin
                    want = pending_cmds.pop_front();
                    if (out_ch.steer_cmd !== want.steer)
                        report_mismatch("steer_cmd", out_ch.steer_cmd, want.steer);
                    if (out_ch.accel_cmd !== want.accel)
                        report_mismatch("accel_cmd", out_ch.accel_cmd, want.accel);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat for %0d cycles", $realtime, quiet);
        $display("FAILURE");
        $finish;
    end

    function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_BITS'(COORD_MAX);
        return COORD_BITS'(v);
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.mode     = 1'($urandom_range(1));
        it.box_x    = COORD_BITS'($urandom_range(COORD_MAX));
        it.box_y    = COORD_BITS'($urandom_range(COORD_MAX));
        it.box_w    = COORD_BITS'($urandom_range(COORD_MAX));
        it.box_h    = COORD_BITS'($urandom_range(COORD_MAX));
        it.stamp_ms = $urandom;
        return it;
    endfunction

    // Must be called at a clock edge; valid stays high afterward unless a gap follows.
    task automatic send_item(input t_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= it.mode;
        in_ch.box_x    <= it.box_x;
        in_ch.box_y    <= it.box_y;
        in_ch.box_w    <= it.box_w;
        in_ch.box_h    <= it.box_h;
        in_ch.stamp_ms <= it.stamp_ms;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_box(input int x, input int y, input int w, input int h,
                            input logic [STAMP_BITS-1:0] stamp);
        t_item it;
        it.mode     = MODE_BOX;
        it.box_x    = clamp_coord(x);
        it.box_y    = clamp_coord(y);
        it.box_w    = clamp_coord(w);
        it.box_h    = clamp_coord(h);
        it.stamp_ms = stamp;
        send_item(it);
    endtask

    // The payload of a tick is ignored, so it carries random bits.
    task automatic send_tick();
        t_item it;
        it = random_item();
        it.mode = MODE_TICK;
        send_item(it);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write.
    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_FRAME_WIDTH:  cfg_shadow.frame_width      = value[FRAME_BITS-1:0];
            CFG_FRAME_HEIGHT: cfg_shadow.frame_height     = value[FRAME_BITS-1:0];
            CFG_X_MARGIN:     cfg_shadow.x_margin         = value[MARGIN_BITS-1:0];
            CFG_Y_MARGIN:     cfg_shadow.y_margin         = value[MARGIN_BITS-1:0];
            CFG_TIMEOUT:      cfg_shadow.stale_timeout_ms = value[TIMEOUT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int fw, input int fh, input int xm, input int ym,
                                input int tmo);
        wait_drained();
        write_one(CFG_FRAME_WIDTH, CFG_DATA_W'(fw));
        write_one(CFG_FRAME_HEIGHT, CFG_DATA_W'(fh));
        write_one(CFG_X_MARGIN, CFG_DATA_W'(xm));
        write_one(CFG_Y_MARGIN, CFG_DATA_W'(ym));
        write_one(CFG_TIMEOUT, CFG_DATA_W'(tmo));
        i_cfg_we <= 1'b0;
    endtask

    // Two boxes and a tick around the current bands and margins, sometimes disturbed.
    task automatic run_episode();
        int w, h, w2, h2, nx, ny, dx, dy;
        logic [STAMP_BITS-1:0] t1, t2;
        if ($urandom_range(9) == 0) begin
            w = $urandom_range(COORD_MAX);
            h = $urandom_range(COORD_MAX);
        end else begin
            w = $urandom_range(1, 48);
            h = $urandom_range(1, 48);
        end
        w2 = w + int'($urandom_range(4)) - 2;
        h2 = h + int'($urandom_range(4)) - 2;
        nx = int'($urandom_range(cfg_shadow.frame_width)) - w2 / 2;
        ny = int'($urandom_range(cfg_shadow.frame_height)) - h2 / 2;
        dx = int'($urandom_range(2 * cfg_shadow.x_margin + 6)) - int'(cfg_shadow.x_margin) - 3;
        dy = int'($urandom_range(2 * cfg_shadow.y_margin + 6)) - int'(cfg_shadow.y_margin) - 3;
        t1 = now_ms;
        case ($urandom_range(9))
            0: t2 = t1 + cfg_shadow.stale_timeout_ms;
            1: t2 = t1 + cfg_shadow.stale_timeout_ms + 1;
            2: t2 = t1 - $urandom_range(1, 5000);
            default: t2 = t1 + $urandom_range(cfg_shadow.stale_timeout_ms);
        endcase
        now_ms = t2 + $urandom_range(50);
        send_box(nx - dx, ny - dy, w, h, t1);
        case ($urandom_range(9))
            0: send_tick();
            1: send_box(nx, ny, w, h, t1);
            default: ;
        endcase
        send_box(nx, ny, w2, h2, t2);
        send_tick();
    endtask

    task automatic run_traffic(input int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 80)
                run_episode();
            else
                send_item(random_item());
        end
    endtask

    task automatic test_directed_cases();
        // Registers still hold their reset values here.
        send_tick();
        send_box(100, 100, 20, 20, 32'd0);
        send_box(90, 100, 20, 20, 32'd10);
        send_tick();
        // The same pair again leaves the codes as they are.
        send_box(100, 100, 20, 20, 32'd20);
        send_box(90, 100, 20, 20, 32'd30);
        send_tick();
        send_box(300, 200, 10, 10, 32'd40);
        send_tick();
        // A gap of exactly the timeout keeps the history; one more clears it.
        send_box(300, 200, 10, 10, 32'd1040);
        send_tick();
        send_box(600, 400, 10, 10, 32'd2000);
        send_box(620, 460, 10, 10, 32'd3001);
        send_tick();
        // An earlier stamp is a negative gap and never times out.
        send_box(600, 400, 10, 10, 32'd5000);
        send_box(620, 460, 10, 10, 32'd10);
        send_tick();
        // Area ratios of exactly 4/5 and 5/4 pass, a third report drops the oldest box,
        // and 5 to 3 is too far apart.
        send_box(300, 200, 5, 1, 32'd6000);
        send_box(300, 200, 4, 1, 32'd6001);
        send_box(300, 200, 5, 1, 32'd6002);
        send_box(300, 200, 3, 1, 32'd6003);
        // Zero area after a nonzero one clears, two zero areas match.
        send_box(300, 200, 0, 7, 32'd6004);
        send_box(300, 200, 9, 0, 32'd6005);
        send_tick();
        // Field extremes, with stamps that wrap through zero.
        send_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FF00);
        send_box(0, 0, COORD_MAX, COORD_MAX, 32'h0000_0010);
        send_tick();
        send_box(0, 0, 0, 0, 32'hFFFF_FFFF);
    endtask

    task automatic test_register_extremes();
        now_ms = $urandom;
        program_regs(1, 1, 0, 0, 0);
        run_traffic(60);
        program_regs(COORD_MAX, COORD_MAX, 255, 255, 65535);
        run_traffic(60);
        // Data wider than a register is cut to its width; spare indexes are ignored.
        wait_drained();
        write_one(CFG_FRAME_WIDTH, 16'hF000);
        write_one(CFG_FRAME_HEIGHT, 16'hFFFF);
        write_one(CFG_X_MARGIN, 16'hFF00);
        write_one(CFG_Y_MARGIN, 16'h01FF);
        write_one(CFG_SPARE_LO, 16'hFFFF);
        write_one(CFG_SPARE_HI, 16'h0000);
        i_cfg_we <= 1'b0;
        run_traffic(60);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
        int round;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        now_ms = $urandom;
        for (round = 0; round < 3; round++) begin
            case (round)
                0: program_regs(640, 480, 6, 3, 1000);
                1: program_regs($urandom_range(1, COORD_MAX), $urandom_range(1, COORD_MAX),
                                $urandom_range(255), $urandom_range(255),
                                $urandom_range(65535));
                default: program_regs($urandom_range(160, 1920), $urandom_range(120, 1080),
                                      $urandom_range(16), $urandom_range(16),
                                      $urandom_range(2000));
            endcase
            run_traffic(n_items / 3);
        end
    endtask

    task automatic test_output_stall();
        int i;
        program_regs(640, 480, 6, 3, 1000);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req++;
        // A centred box and a fast leftward move alternate, so every tick changes the
        // codes and the blocked output soon backs up into the input.
        for (i = 0; i < 24; i++) begin
            if (i % 2 == 0) begin
                send_box(315, 235, 10, 10, now_ms);
                send_box(315, 235, 10, 10, now_ms);
            end else begin
                send_box(40, 235, 10, 10, now_ms);
                send_box(0, 235, 10, 10, now_ms);
            end
            send_tick();
        end
        wait_drained();
    endtask

    initial begin
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_BOX;
        in_ch.box_x    = '0;
        in_ch.box_y    = '0;
        in_ch.box_w    = '0;
        in_ch.box_h    = '0;
        in_ch.stamp_ms = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_FRAME_WIDTH;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        cfg_shadow = '{frame_width: 12'd640, frame_height: 12'd480, x_margin: 8'd6,
                       y_margin: 8'd3, stale_timeout_ms: 16'd1000};
        hist_count = 0;
        {new_x, new_y, new_w, new_h, old_x, old_y} = '0;
        new_stamp  = '0;
        held_cmd   = '{steer: STEER_STRAIGHT, accel: ACCEL_SLOW};
        src_idle_pct = 34;
        snk_idle_pct = 63;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_register_extremes();
        test_random_traffic(34, 63, 480);
        test_random_traffic(63, 34, 480);
        test_random_traffic(0, 0, 480);
        test_output_stall();
        wait_drained();

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tbsd_pkg.sv
rtl/tbsd_in_if.sv
rtl/tbsd_out_if.sv
rtl/tbsd_history.sv
rtl/tbsd_decide.sv
rtl/track_box_steer_decider.sv
dv/tb_track_box_steer_decider.sv
